[rtl/core/bts_pkg.sv]
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared widths, opcodes and queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none
package bts_pkg;
    localparam int MAX_SIDE     = 64;
    localparam int SIDE_W       = $clog2(MAX_SIDE);
    localparam int ADDR_W       = 2 * SIDE_W;
    localparam int DEPTH        = MAX_SIDE * MAX_SIDE;
    localparam int CHANNEL_BITS = 16;
    localparam int TEXEL_W      = 4 * CHANNEL_BITS;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int INDEX_W      = 12;
    localparam int COORD_W      = 17;
    localparam int FRAC_W       = 16;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR   = 2'd3;

    localparam logic signed [CHANNEL_BITS-1:0] ALPHA_ONE = 16'sd256;

    typedef struct packed {
        logic                 is_write;
        logic [ADDR_W-1:0]    addr0;
        logic [ADDR_W-1:0]    addr1;
        logic [ADDR_W-1:0]    addr2;
        logic [ADDR_W-1:0]    addr3;
        logic [FRAC_W-1:0]    fx;
        logic [FRAC_W-1:0]    fy;
        logic                 linear;
        logic [2:0]           chans;
        logic [TEXEL_W-1:0]   texel;
    } t_cmd;

    localparam int QDEPTH = 2;
endpackage
`default_nettype wire

[rtl/core/bts_front.sv]
// ----------------------------------------------------------------------------
// Bilinear texture sampler front end
// Accepts items, scales coordinates, forms texel addresses, queues commands.
// ----------------------------------------------------------------------------
`default_nettype none
module bts_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_opcode,
    input  wire logic [bts_pkg::INDEX_W-1:0]    i_texel_index,
    input  wire logic [bts_pkg::TEXEL_W-1:0]    i_texel,
    input  wire logic [bts_pkg::COORD_W-1:0]    i_coord_u,
    input  wire logic [bts_pkg::COORD_W-1:0]    i_coord_v,
    input  wire logic [6:0]                     i_width,
    input  wire logic [6:0]                     i_height,
    input  wire logic [2:0]                     i_chans,
    input  wire logic                           i_linear,
    output bts_pkg::t_cmd                       o_cmd,
    output logic                                o_cmd_valid,
    input  wire logic                           i_cmd_take
);
    localparam int SW = bts_pkg::SIDE_W;

    // stage 1 register: scaled coordinates
    logic                         r_s1_valid;
    logic                         r_s1_write;
    logic [bts_pkg::INDEX_W-1:0]  r_s1_index;
    logic [bts_pkg::TEXEL_W-1:0]  r_s1_texel;
    logic [bts_pkg::COORD_W+SW-1:0] r_pu, r_pv;
    logic [SW:0]                  r_w, r_h;
    logic                         r_s1_linear;
    logic [2:0]                   r_s1_chans;

    bts_pkg::t_cmd r_q [bts_pkg::QDEPTH];
    logic [1:0]    r_cnt;
    logic          r_rd, r_wr;

    logic [SW:0] w_c, h_c;
    logic [bts_pkg::COORD_W-1:0] u_s, v_s;
    logic [SW:0] x1, y1, x2, y2;
    logic [bts_pkg::ADDR_W+1:0] row1, row2;
    bts_pkg::t_cmd cmd;
    logic accept, push, pop;

    always_comb begin
        w_c = (i_width == 7'd0) ? (SW+1)'(1) :
              (i_width > 7'(bts_pkg::MAX_SIDE)) ? (SW+1)'(bts_pkg::MAX_SIDE) : i_width[SW:0];
        h_c = (i_height == 7'd0) ? (SW+1)'(1) :
              (i_height > 7'(bts_pkg::MAX_SIDE)) ? (SW+1)'(bts_pkg::MAX_SIDE) : i_height[SW:0];
        u_s = (i_coord_u > 17'h10000) ? 17'h10000 : i_coord_u;
        v_s = (i_coord_v > 17'h10000) ? 17'h10000 : i_coord_v;
    end

    // stage 1 may advance only if the queue has room for what it holds
    assign o_stall = r_s1_valid && (r_cnt == 2'(bts_pkg::QDEPTH)) && !pop;
    assign accept  = i_valid && !o_stall;
    assign push    = r_s1_valid && !o_stall;
    assign pop     = o_cmd_valid && i_cmd_take;

    always_comb begin
        x1 = r_pu[bts_pkg::COORD_W+SW-1:16];
        y1 = r_pv[bts_pkg::COORD_W+SW-1:16];
        x2 = ((x1 + 1'b1) >= r_w) ? r_w - 1'b1 : x1 + 1'b1;
        y2 = ((y1 + 1'b1) >= r_h) ? r_h - 1'b1 : y1 + 1'b1;
        row1 = (bts_pkg::ADDR_W+2)'(y1 * r_w);
        row2 = (bts_pkg::ADDR_W+2)'(y2 * r_w);
        cmd.is_write = r_s1_write;
        cmd.addr0    = bts_pkg::ADDR_W'(row1 + x1);
        cmd.addr1    = bts_pkg::ADDR_W'(row1 + x2);
        cmd.addr2    = bts_pkg::ADDR_W'(row2 + x1);
        cmd.addr3    = bts_pkg::ADDR_W'(row2 + x2);
        if (r_s1_write) begin
            cmd.addr0 = r_s1_index[bts_pkg::ADDR_W-1:0];
        end
        cmd.fx     = r_pu[15:0];
        cmd.fy     = r_pv[15:0];
        cmd.linear = r_s1_linear;
        cmd.chans  = r_s1_chans;
        cmd.texel  = r_s1_texel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= accept && !(i_opcode == bts_pkg::OP_WRITE &&
                          (bts_pkg::INDEX_W+1)'(i_texel_index) >=
                          (bts_pkg::INDEX_W+1)'(bts_pkg::DEPTH));
        end
        if (!o_stall) begin
            r_s1_write  <= (i_opcode == bts_pkg::OP_WRITE);
            r_s1_index  <= i_texel_index;
            r_s1_texel  <= i_texel;
            r_pu        <= (bts_pkg::COORD_W+SW)'(u_s * (w_c - 1'b1));
            r_pv        <= (bts_pkg::COORD_W+SW)'(v_s * (h_c - 1'b1));
            r_w         <= w_c;
            r_h         <= h_c;
            r_s1_linear <= i_linear;
            r_s1_chans  <= i_chans;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
        if (push) r_q[r_wr] <= cmd;
    end
endmodule
`default_nettype wire

[rtl/core/bts_back.sv]
// ----------------------------------------------------------------------------
// Bilinear texture sampler back end
// Texel store, one read per point sample or four sequential reads per bilinear
// sample, lerps and output register.
`default_nettype none
module bts_back (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  bts_pkg::t_cmd                               i_cmd,
    input  wire logic                                   i_cmd_valid,
    output logic                                        o_cmd_take,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [bts_pkg::CHANNEL_BITS-1:0]     o_red,
    output logic signed [bts_pkg::CHANNEL_BITS-1:0]     o_green,
    output logic signed [bts_pkg::CHANNEL_BITS-1:0]     o_blue,
    output logic signed [bts_pkg::CHANNEL_BITS-1:0]     o_alpha
);
    localparam int CB = bts_pkg::CHANNEL_BITS;

    typedef enum logic [2:0] {S_IDLE, S_RD1, S_RD2, S_RD3, S_WAIT, S_LX, S_LY, S_OUT} t_state;

    logic [bts_pkg::TEXEL_W-1:0] r_mem [bts_pkg::DEPTH];
    logic [bts_pkg::TEXEL_W-1:0] r_rdata;
    t_state        r_state;
    bts_pkg::t_cmd r_cmd;
    logic [bts_pkg::TEXEL_W-1:0] r_t0, r_t1, r_t2;
    logic signed [CB-1:0] r_a [4];
    logic signed [CB-1:0] r_b [4];
    logic                 r_ov;

    logic [bts_pkg::ADDR_W-1:0] rd_addr;
    logic do_read;
    logic signed [CB-1:0] n_l0 [4];
    logic signed [CB-1:0] n_l1 [4];
    logic signed [CB-1:0] n_ly [4];
    logic signed [CB-1:0] res [4];

    function automatic logic signed [CB-1:0] lerp(input logic signed [CB-1:0] a,
            input logic signed [CB-1:0] b, input logic [15:0] f);
        logic signed [CB:0]    d;
        logic signed [CB+17:0] p;
        begin
            d = (CB+1)'(b) - (CB+1)'(a);
            p = d * $signed({1'b0, f});
            lerp = CB'(a + CB'(p >>> 16));
        end
    endfunction

    function automatic logic signed [CB-1:0] ch(input logic [bts_pkg::TEXEL_W-1:0] t,
            input int c);
        ch = t[c*CB +: CB];
    endfunction

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        case (r_state)
            S_RD1:   rd_addr = r_cmd.addr1;
            S_RD2:   rd_addr = r_cmd.addr2;
            S_RD3:   rd_addr = r_cmd.addr3;
            default: rd_addr = i_cmd.addr0;
        endcase
        do_read = (o_cmd_take && !i_cmd.is_write) || r_state == S_RD1 ||
                  r_state == S_RD2 || r_state == S_RD3;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && i_cmd.is_write) r_mem[i_cmd.addr0] <= i_cmd.texel;
        if (do_read) r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_l0[c] = lerp(ch(r_t0, c), ch(r_t1, c), r_cmd.fx);
            n_l1[c] = lerp(ch(r_t2, c), ch(r_rdata, c), r_cmd.fx);
            n_ly[c] = lerp(r_a[c], r_b[c], r_cmd.fy);
        end
        for (int c = 0; c < 4; c++) res[c] = r_cmd.linear ? n_ly[c] : ch(r_t0, c);
        if (r_cmd.chans < 3'd2 && r_cmd.chans != 3'd0 || r_cmd.chans == 3'd0) res[1] = '0;
        if (r_cmd.chans < 3'd3) res[2] = '0;
        if (r_cmd.chans < 3'd4) res[3] = bts_pkg::ALPHA_ONE;
    end

    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        if (!i_cmd.is_write)
                            r_state <= i_cmd.linear ? S_RD1 : S_WAIT;
                    end
                end
                S_RD1: begin
                    r_t0 <= r_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_t1 <= r_rdata;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_t2 <= r_rdata;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_cmd.linear) begin
                        r_state <= S_LX;
                    end else begin
                        r_t0 <= r_rdata;
                        r_state <= S_OUT;
                    end
                end
                S_LX: begin
                    for (int c = 0; c < 4; c++) begin
                        r_a[c] <= n_l0[c];
                        r_b[c] <= n_l1[c];
                    end
                    r_state <= S_LY;
                end
                S_LY: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        o_red   <= res[0];
                        o_green <= res[1];
                        o_blue  <= res[2];
                        o_alpha <= res[3];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/bilinear_texture_sampler.sv]
// ----------------------------------------------------------------------------
// Bilinear texture sampler
// 64x64 RGBA Q8.8 texture store with point and bilinear sampling.
// ----------------------------------------------------------------------------
// Input channel i_valid/o_stall carries write or sample items; output channel
// o_valid/i_stall carries one result per sample, none per write.
// The user must write the config registers (width, height, channels, linear)
// via i_cfg_we/i_cfg_idx/i_cfg_data only while idle; the block does not check.
// The front end scales u,v and forms addresses in one registered stage, then
// queues a command in a two-entry queue. The back end owns the single-port
// texel store: a write is done when its command is taken; a point sample
// reads one texel, a bilinear sample reads four through one port and passes
// two lerp stages before the output register. The back end takes a new
// command only when it is back in idle.
// Reset clears control state and loads 64x64, RGBA, point filtering; texel
// contents are undefined until written. When i_stall is held the result
// stays in the output register and the queue, then the input, fill up.
// ----------------------------------------------------------------------------
`default_nettype none
module bilinear_texture_sampler (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [bts_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic                                   i_opcode,
    input  wire logic [11:0]                            i_texel_index,
    input  wire logic signed [15:0]                     i_in_red,
    input  wire logic signed [15:0]                     i_in_green,
    input  wire logic signed [15:0]                     i_in_blue,
    input  wire logic signed [15:0]                     i_in_alpha,
    input  wire logic [16:0]                            i_coord_u,
    input  wire logic [16:0]                            i_coord_v,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [15:0]                          o_out_red,
    output logic signed [15:0]                          o_out_green,
    output logic signed [15:0]                          o_out_blue,
    output logic signed [15:0]                          o_out_alpha
);
    logic [6:0] r_width, r_height;
    logic [2:0] r_chans;
    logic       r_linear;
    bts_pkg::t_cmd cmd;
    logic cmd_valid, cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
            r_chans  <= 3'd4;
            r_linear <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bts_pkg::REG_WIDTH:    r_width  <= i_cfg_data;
                bts_pkg::REG_HEIGHT:   r_height <= i_cfg_data;
                bts_pkg::REG_CHANNELS: r_chans  <= i_cfg_data[2:0];
                bts_pkg::REG_LINEAR:   r_linear <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    bts_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode, .i_texel_index,
        .i_texel({i_in_alpha, i_in_blue, i_in_green, i_in_red}),
        .i_coord_u, .i_coord_v,
        .i_width(r_width), .i_height(r_height),
        .i_chans(r_chans == 3'd0 ? 3'd1 : (r_chans > 3'd4 ? 3'd4 : r_chans)),
        .i_linear(r_linear),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take)
    );

    bts_back u_back (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .o_valid, .i_stall,
        .o_red(o_out_red), .o_green(o_out_green), .o_blue(o_out_blue),
        .o_alpha(o_out_alpha)
    );
endmodule
`default_nettype wire

[tb/sv/bilinear_texture_sampler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bilinear texture sampler testbench
// Fills the low part of the texel store, then runs a table of directed
// transfers and random write/sample traffic over several register settings
// (sizes, channel counts, point and bilinear filtering, out-of-range values).
// Samples only touch written texels. Each sample is predicted by an in-bench
// texture model or the directed table and checked field by field.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_tb;

    typedef struct packed {
        logic signed [15:0] r;
        logic signed [15:0] g;
        logic signed [15:0] b;
        logic signed [15:0] a;
    } t_texel;

    typedef struct {
        logic        op;
        logic [11:0] idx;
        t_texel      pix;
        logic [16:0] u;
        logic [16:0] v;
        bit          typed;
        t_texel      want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [bts_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = bts_pkg::OP_WRITE;
    logic [11:0] i_texel_index = '0;
    logic signed [15:0] i_in_red = '0, i_in_green = '0, i_in_blue = '0, i_in_alpha = '0;
    logic [16:0] i_coord_u = '0, i_coord_v = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [15:0] o_out_red, o_out_green, o_out_blue, o_out_alpha;

    bilinear_texture_sampler u_top (.*);

    always #10 i_clk = ~i_clk;

    t_texel      tex_mem [bts_pkg::DEPTH];
    bit          seen [bts_pkg::DEPTH];
    logic [6:0]  cfg_w = 7'd64, cfg_h = 7'd64;
    logic [2:0]  cfg_ch = 3'd4;
    logic        cfg_lin = 1'b0;
    t_texel      pending_q [$];
    int          errors = 0, samples_done = 0, items_sent = 0;
    int          cycles = 0;
    int          hold_left = 0, rx_wait = 0;
    bit          quiet = 1'b0, tx_nogap = 1'b0;

    function automatic longint lerp16(longint a, longint b, longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic t_texel sample_texture(logic [16:0] cu, logic [16:0] cv);
        int unsigned w, h, u, v, x1, y1, x2, y2, fx, fy, cc, pu, pv;
        longint      p [4][4];
        longint      res [4];
        t_texel      t;
        w  = (cfg_w == 0) ? 1 : ((cfg_w > bts_pkg::MAX_SIDE) ? bts_pkg::MAX_SIDE : cfg_w);
        h  = (cfg_h == 0) ? 1 : ((cfg_h > bts_pkg::MAX_SIDE) ? bts_pkg::MAX_SIDE : cfg_h);
        u  = (cu > 17'h10000) ? 32'h10000 : cu;
        v  = (cv > 17'h10000) ? 32'h10000 : cv;
        pu = u * (w - 1);
        pv = v * (h - 1);
        x1 = pu >> 16; y1 = pv >> 16;
        fx = pu & 16'hFFFF; fy = pv & 16'hFFFF;
        x2 = (x1 + 1 >= w) ? w - 1 : x1 + 1;
        y2 = (y1 + 1 >= h) ? h - 1 : y1 + 1;
        for (int k = 0; k < 4; k++) begin
            t = tex_mem[((k < 2) ? y1 : y2) * w + ((k % 2) ? x2 : x1)];
            p[k][0] = t.r; p[k][1] = t.g; p[k][2] = t.b; p[k][3] = t.a;
        end
        for (int c = 0; c < 4; c++) begin
            if (cfg_lin)
                res[c] = lerp16(lerp16(p[0][c], p[1][c], fx),
                                lerp16(p[2][c], p[3][c], fx), fy);
            else
                res[c] = p[0][c];
        end
        cc = (cfg_ch == 0) ? 1 : ((cfg_ch > 4) ? 4 : cfg_ch);
        if (cc < 2) res[1] = 0;
        if (cc < 3) res[2] = 0;
        if (cc < 4) res[3] = bts_pkg::ALPHA_ONE;
        t.r = res[0][15:0]; t.g = res[1][15:0]; t.b = res[2][15:0]; t.a = res[3][15:0];
        return t;
    endfunction

    // true for writes, and for a sample when every texel it reads has been written
    function automatic bit ready(t_row rw);
        int unsigned w, h, u, v, x1, y1, x2, y2, pu, pv;
        if (rw.op == bts_pkg::OP_WRITE)
            return 1'b1;
        w  = (cfg_w == 0) ? 1 : ((cfg_w > bts_pkg::MAX_SIDE) ? bts_pkg::MAX_SIDE : cfg_w);
        h  = (cfg_h == 0) ? 1 : ((cfg_h > bts_pkg::MAX_SIDE) ? bts_pkg::MAX_SIDE : cfg_h);
        u  = (rw.u > 17'h10000) ? 32'h10000 : rw.u;
        v  = (rw.v > 17'h10000) ? 32'h10000 : rw.v;
        pu = u * (w - 1);
        pv = v * (h - 1);
        x1 = pu >> 16; y1 = pv >> 16;
        x2 = (x1 + 1 >= w) ? w - 1 : x1 + 1;
        y2 = (y1 + 1 >= h) ? h - 1 : y1 + 1;
        if (!cfg_lin)
            return seen[y1 * w + x1];
        return seen[y1 * w + x1] && seen[y1 * w + x2] &&
               seen[y2 * w + x1] && seen[y2 * w + x2];
    endfunction

    // waits until every expected result has arrived, then idles so writes finish
    task automatic drain();
        wait (pending_q.size() == 0);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [bts_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            bts_pkg::REG_WIDTH:    cfg_w = val;
            bts_pkg::REG_HEIGHT:   cfg_h = val;
            bts_pkg::REG_CHANNELS: cfg_ch = val[2:0];
            bts_pkg::REG_LINEAR:   cfg_lin = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [6:0] w, logic [6:0] h, logic [2:0] ch, logic lin);
        drain();
        write_reg(bts_pkg::REG_WIDTH, w);
        write_reg(bts_pkg::REG_HEIGHT, h);
        write_reg(bts_pkg::REG_CHANNELS, {4'd0, ch});
        write_reg(bts_pkg::REG_LINEAR, {6'd0, lin});
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic send(t_row rw);
        int gap;
        i_valid = 1'b1; i_opcode = rw.op; i_texel_index = rw.idx;
        i_in_red = rw.pix.r; i_in_green = rw.pix.g;
        i_in_blue = rw.pix.b; i_in_alpha = rw.pix.a;
        i_coord_u = rw.u; i_coord_v = rw.v;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (rw.op == bts_pkg::OP_WRITE) begin
            tex_mem[rw.idx] = rw.pix;
            seen[rw.idx] = 1'b1;
        end else begin
            pending_q.push_back(rw.typed ? rw.want : sample_texture(rw.u, rw.v));
        end
        @(negedge i_clk);
        gap = (quiet || tx_nogap) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_row rand_row();
        t_row rw;
        rw.op    = ($urandom_range(0, 3) == 0) ? bts_pkg::OP_WRITE : bts_pkg::OP_SAMPLE;
        rw.idx   = 12'($urandom());
        rw.pix   = {$urandom(), $urandom()};
        rw.typed = 1'b0;
        rw.want  = '0;
        case ($urandom_range(0, 5))
            0: rw.u = 17'h0;
            1: rw.u = 17'h10000;
            2: rw.u = 17'($urandom_range(17'h10001, 17'h1FFFF));
            default: rw.u = 17'($urandom_range(0, 17'hFFFF));
        endcase
        case ($urandom_range(0, 5))
            0: rw.v = 17'h0;
            1: rw.v = 17'h10000;
            2: rw.v = 17'($urandom_range(17'h10001, 17'h1FFFF));
            default: rw.v = 17'($urandom_range(0, 17'hFFFF));
        endcase
        return rw;
    endfunction

    t_row directed [8] = '{
        '{bts_pkg::OP_WRITE,  12'd0,    {16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF},
          17'd0, 17'd0, 0, '0},
        '{bts_pkg::OP_SAMPLE, 12'd0,    '0, 17'd0, 17'd0, 1,
          {16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF}},
        '{bts_pkg::OP_WRITE,  12'd4095, {16'sh7FFF, 16'sh8000, 16'sh0100, 16'shFF00},
          17'd0, 17'd0, 0, '0},
        '{bts_pkg::OP_SAMPLE, 12'd0,    '0, 17'h10000, 17'h10000, 1,
          {16'sh7FFF, 16'sh8000, 16'sh0100, 16'shFF00}},
        '{bts_pkg::OP_SAMPLE, 12'd0,    '0, 17'h1FFFF, 17'h1FFFF, 1,
          {16'sh7FFF, 16'sh8000, 16'sh0100, 16'shFF00}},
        '{bts_pkg::OP_SAMPLE, 12'd0,    '0, 17'h08000, 17'h01FFF, 0, '0},
        '{bts_pkg::OP_WRITE,  12'd63,   {16'sh1234, 16'shEDCB, 16'sh0001, 16'sh7F00},
          17'd0, 17'd0, 0, '0},
        '{bts_pkg::OP_SAMPLE, 12'd0,    '0, 17'h10000, 17'h0, 1,
          {16'sh1234, 16'shEDCB, 16'sh0001, 16'sh7F00}}
    };

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("** bilinear_texture_sampler: FAILED **");
            $finish;
        end
    end

    // result check and receiver stall draw
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                t_texel e;
                e = pending_q.pop_front();
                samples_done++;
                if (o_out_red !== e.r) begin
                    $error("out_red exp %0d got %0d", e.r, o_out_red); errors++;
                end
                if (o_out_green !== e.g) begin
                    $error("out_green exp %0d got %0d", e.g, o_out_green); errors++;
                end
                if (o_out_blue !== e.b) begin
                    $error("out_blue exp %0d got %0d", e.b, o_out_blue); errors++;
                end
                if (o_out_alpha !== e.a) begin
                    $error("out_alpha exp %0d got %0d", e.a, o_out_alpha); errors++;
                end
            end
            rx_wait = quiet ? 0 : $urandom_range(0, 10);
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall = 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall = 1'b1;
        end else begin
            i_stall = 1'b0;
        end
    end

    initial begin
        t_row rw;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill the low entries; later samples only read written texels
        tx_nogap = 1'b1;
        for (int k = 0; k < 512; k++) begin
            rw = '{bts_pkg::OP_WRITE, k[11:0], {$urandom(), $urandom()}, 17'd0, 17'd0, 0, '0};
            send(rw);
        end
        tx_nogap = 1'b0;

        foreach (directed[k])
            send(directed[k]);
        i_valid = 1'b0;

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:  set_config(7'd64, 7'd64, 3'd4, 1'b1);
                1:  set_config(7'd1, 7'd1, 3'd1, 1'b1);
                2:  set_config(7'd0, 7'd0, 3'd0, 1'b0);
                3:  set_config(7'd127, 7'd127, 3'd7, 1'b1);
                4:  set_config(7'd17, 7'd5, 3'd2, 1'b1);
                5:  set_config(7'd5, 7'd33, 3'd3, 1'b0);
                6:  set_config(7'd2, 7'd2, 3'd4, 1'b1);
                7:  set_config(7'd64, 7'd1, 3'd3, 1'b1);
                default: set_config(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                    3'($urandom_range(1, 4)), 1'($urandom()));
            endcase
            quiet = (ph == 6);
            if (ph == 3) begin
                hold_left = 300;
                tx_nogap = 1'b1;
                repeat (40) begin
                    do begin
                        rw = rand_row();
                        rw.op = bts_pkg::OP_SAMPLE;
                    end while (!ready(rw));
                    send(rw);
                end
                tx_nogap = 1'b0;
            end
            if (ph == 8) begin
                i_valid = 1'b0;
                wait (pending_q.size() == 0);
                @(negedge i_clk);
            end
            repeat (100) begin
                do rw = rand_row(); while (!ready(rw));
                send(rw);
            end
            i_valid = 1'b0;
        end
        quiet = 1'b0;

        fork
            drain();
            begin
                repeat (200000) @(negedge i_clk);
            end
        join_any
        disable fork;
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d transfers in, %0d samples checked over 12 settings,",
                 items_sent, samples_done);
        $display("point and bilinear filtering, clamped sizes and channel counts.");
        if (errors == 0 && pending_q.size() == 0)
            $display("** bilinear_texture_sampler: PASSED **");
        else
            $display("** bilinear_texture_sampler: FAILED **");
        $finish;
    end
endmodule

[bilinear_texture_sampler.f]
rtl/core/bts_pkg.sv
rtl/core/bts_front.sv
rtl/core/bts_back.sv
rtl/core/bilinear_texture_sampler.sv
tb/sv/bilinear_texture_sampler_tb.sv
